// ===== rtl/smf_pkg.sv =====
// Shared types and constants for the sliding window median filter.
package smf_pkg;

  localparam int unsigned CFG_BITS    = 7;
  localparam int unsigned IN_DATA_W   = 32;
  localparam int unsigned MED_W       = 33;
  localparam int unsigned OUT_DATA_W  = 40;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic update;
    logic full;
  } cell_ctrl_t;

endpackage

// ===== rtl/smf_cell.sv =====
// One sorted cell: holds a sample and its age, removes and inserts with its neighbors.
module smf_cell #(
  parameter int unsigned SAMPLE_BITS = 32,
  parameter int unsigned AGE_BITS    = 6,
  parameter int unsigned CNT_BITS    = 7,
  parameter int unsigned IDX         = 0
) (
  input  logic                          clk_i,
  input  smf_pkg::cell_ctrl_t           ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] x_i,
  input  logic signed [SAMPLE_BITS-1:0] vr_i,
  input  logic [CNT_BITS-1:0]           size_i,
  input  logic [CNT_BITS-1:0]           limit_i,
  input  logic signed [SAMPLE_BITS-1:0] left_val_i,
  input  logic [AGE_BITS-1:0]           left_age_i,
  input  logic                          left_atr_i,
  input  logic                          left_stays_i,
  input  logic signed [SAMPLE_BITS-1:0] right_val_i,
  input  logic [AGE_BITS-1:0]           right_age_i,
  input  logic                          right_lt_i,
  output logic signed [SAMPLE_BITS-1:0] val_o,
  output logic [AGE_BITS-1:0]           age_o,
  output logic                          lt_o,
  output logic                          atr_o,
  output logic                          stays_o,
  output logic                          rm_o
);

  localparam logic [CNT_BITS-1:0] IDX_C = CNT_BITS'(IDX);

  logic signed [SAMPLE_BITS-1:0] val_q, val_d;
  logic [AGE_BITS-1:0]           age_q, age_d;
  logic signed [SAMPLE_BITS-1:0] a_val, la_val;
  logic [AGE_BITS-1:0]           a_age, la_age;
  logic                          gtr;

  always_comb begin
    lt_o    = val_q < x_i;
    gtr     = val_q > vr_i;
    rm_o    = ctrl_i.full && (IDX_C < size_i) &&
              (CNT_BITS'(age_q) == size_i - CNT_BITS'(1));
    atr_o   = ctrl_i.full && (rm_o || gtr);
    a_val   = atr_o ? right_val_i : val_q;
    a_age   = atr_o ? right_age_i : age_q;
    la_val  = left_atr_i ? val_q : left_val_i;
    la_age  = left_atr_i ? age_q : left_age_i;
    stays_o = (IDX_C < limit_i) && (atr_o ? right_lt_i : lt_o);
    if (stays_o) begin
      val_d = a_val;
      age_d = a_age + AGE_BITS'(1);
    end else if (left_stays_i) begin
      val_d = x_i;
      age_d = '0;
    end else begin
      val_d = la_val;
      age_d = la_age + AGE_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.update) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign val_o = val_q;
  assign age_o = age_q;

endmodule

// ===== rtl/sliding_window_median_filter.sv =====
// Top level of the sliding window median filter: control, cell row and median output.
//
// Input samples arrive on the s_axis channel; tdata carries the sample and tuser
// carries the restart flag, which empties the window before the sample enters.
// Results leave on the m_axis channel as twice the window median, a signed value
// with one fractional bit. No result is given while the window is still filling.
// The window size is written on the cfg channel; a write also empties the window.
// The sorted window lives in a row of cells; each cell compares against the new
// and the outgoing sample and takes its next value from itself or a neighbor,
// so one insert and one removal complete in the same update of the row.
// An item passes through the transfer, which picks the outgoing value, then the
// update of the cell row, then the median selection into the output register.
// A sample that gives no result skips the median selection.
// The input accepts a new transfer while the previous result waits in the output
// register; if the receiver stalls, the block holds in its result step until
// the output register is free, and no data is lost.
// After reset the window is empty and the window size is 3.
module sliding_window_median_filter #(
  parameter int unsigned WINDOW_MAX  = 64,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // sample
  input  logic [smf_pkg::IN_DATA_W-1:0]         s_axis_tdata_i,
  // restart
  input  logic                                  s_axis_tuser_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // median_doubled, then zero fill
  output logic [smf_pkg::OUT_DATA_W-1:0]        m_axis_tdata_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [smf_pkg::CFG_BITS-1:0]          cfg_data_i
);

  localparam int unsigned CW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  smf_pkg::state_e state_q, state_d;

  logic [smf_pkg::CFG_BITS-1:0]  size_q;
  logic [CW-1:0]                 count_q, count_d;
  logic [CW-1:0]                 limit_q, limit_d;
  logic                          full_q, emit_q;
  logic signed [SAMPLE_BITS-1:0] x_q, vr_q, vr_d;
  logic [smf_pkg::MED_W-1:0]     med_q, med_d;
  logic                          out_valid_q;

  logic [CW-1:0]                 eff_size;
  logic [CW-1:0]                 base;
  logic                          full_now, emit_now;
  logic                          in_xfer, out_xfer, load_out;
  smf_pkg::cell_ctrl_t           ctrl;

  logic signed [SAMPLE_BITS-1:0] cell_val   [WINDOW_MAX];
  logic [AW-1:0]                 cell_age   [WINDOW_MAX];
  logic                          cell_lt    [WINDOW_MAX];
  logic                          cell_atr   [WINDOW_MAX];
  logic                          cell_stays [WINDOW_MAX];
  logic                          cell_rm    [WINDOW_MAX];

  always_comb begin
    if (size_q == '0) begin
      eff_size = CW'(1);
    end else if (int'(size_q) > int'(WINDOW_MAX)) begin
      eff_size = CW'(WINDOW_MAX);
    end else begin
      eff_size = CW'(size_q);
    end
  end

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = out_valid_q && m_axis_tready_i;
  assign load_out = (state_q == smf_pkg::ST_RESULT) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    base     = s_axis_tuser_i ? '0 : count_q;
    full_now = !s_axis_tuser_i && (count_q >= eff_size);
    emit_now = full_now || ((base + CW'(1)) == eff_size);
    count_d  = full_now ? count_q : base + CW'(1);
    limit_d  = full_now ? eff_size - CW'(1) : base;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      smf_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = smf_pkg::ST_UPDATE;
        end
      end
      smf_pkg::ST_UPDATE: begin
        state_d = emit_q ? smf_pkg::ST_RESULT : smf_pkg::ST_IDLE;
      end
      smf_pkg::ST_RESULT: begin
        if (load_out) begin
          state_d = smf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = smf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    ctrl.update     = 1'b0;
    ctrl.full       = full_q;
    unique case (state_q)
      smf_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        ctrl.full       = full_now;
      end
      smf_pkg::ST_UPDATE: begin
        ctrl.update = 1'b1;
      end
      smf_pkg::ST_RESULT: begin
        ctrl.update = 1'b0;
      end
      default: begin
        ctrl.update = 1'b0;
      end
    endcase
  end

  assign cfg_ready_o = 1'b1;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] left_val, right_val;
    logic [AW-1:0]                 left_age, right_age;
    logic                          left_atr, left_stays, right_lt;

    if (i == 0) begin : g_first
      assign left_val   = '0;
      assign left_age   = '0;
      assign left_atr   = 1'b0;
      assign left_stays = 1'b1;
    end else begin : g_inner_left
      assign left_val   = cell_val[i-1];
      assign left_age   = cell_age[i-1];
      assign left_atr   = cell_atr[i-1];
      assign left_stays = cell_stays[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_last
      assign right_val = '0;
      assign right_age = '0;
      assign right_lt  = 1'b0;
    end else begin : g_inner_right
      assign right_val = cell_val[i+1];
      assign right_age = cell_age[i+1];
      assign right_lt  = cell_lt[i+1];
    end

    smf_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .AGE_BITS    (AW),
      .CNT_BITS    (CW),
      .IDX         (i)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .x_i          (x_q),
      .vr_i         (vr_q),
      .size_i       (eff_size),
      .limit_i      (limit_q),
      .left_val_i   (left_val),
      .left_age_i   (left_age),
      .left_atr_i   (left_atr),
      .left_stays_i (left_stays),
      .right_val_i  (right_val),
      .right_age_i  (right_age),
      .right_lt_i   (right_lt),
      .val_o        (cell_val[i]),
      .age_o        (cell_age[i]),
      .lt_o         (cell_lt[i]),
      .atr_o        (cell_atr[i]),
      .stays_o      (cell_stays[i]),
      .rm_o         (cell_rm[i])
    );
  end

  // The outgoing sample is the one cell whose age equals the window size minus one.
  always_comb begin
    vr_d = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (cell_rm[i]) begin
        vr_d = vr_d | cell_val[i];
      end
    end
  end

  always_comb begin
    logic [CW-1:0]                 mid;
    logic                          odd;
    logic signed [SAMPLE_BITS-1:0] va, vb;
    logic signed [SAMPLE_BITS:0]   sum;
    mid = eff_size >> 1;
    odd = eff_size[0];
    va  = '0;
    vb  = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (CW'(i) == mid) begin
        va = va | cell_val[i];
      end
      if ((odd && (CW'(i) == mid)) || (!odd && ((CW'(i) + CW'(1)) == mid))) begin
        vb = vb | cell_val[i];
      end
    end
    sum   = {va[SAMPLE_BITS-1], va} + {vb[SAMPLE_BITS-1], vb};
    med_d = smf_pkg::MED_W'(sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smf_pkg::ST_IDLE;
      size_q      <= smf_pkg::CFG_BITS'(3);
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        size_q  <= cfg_data_i;
        count_q <= '0;
      end else if (in_xfer) begin
        count_q <= count_d;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      x_q     <= s_axis_tdata_i[SAMPLE_BITS-1:0];
      vr_q    <= vr_d;
      full_q  <= full_now;
      emit_q  <= emit_now;
      limit_q <= limit_d;
    end
    if (load_out) begin
      med_q <= med_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(smf_pkg::OUT_DATA_W - smf_pkg::MED_W){1'b0}}, med_q};

endmodule

// ===== verif/sliding_window_median_filter_tb.sv =====
// Self-checking testbench for the sliding window median filter.
`timescale 1ns / 1ps

module sliding_window_median_filter_tb;

  localparam int unsigned WIN_MAX     = 64;
  localparam int unsigned RAND_ITEMS  = 1250;
  localparam int unsigned SETTLE_CYC  = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DIR_ROWS    = 24;

  typedef enum bit {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [6:0]  win;
    logic [31:0] smp;
    logic        restart;
    logic        typed;
    logic [32:0] med;
  } dir_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid_i;
  logic                          s_axis_tready_o;
  logic [smf_pkg::IN_DATA_W-1:0] s_axis_tdata_i;
  logic                          s_axis_tuser_i;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i;
  logic [smf_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [smf_pkg::CFG_BITS-1:0]  cfg_data_i;

  // Predictor state: window size, samples in arrival order and in ascending order.
  logic [6:0]         window_reg;
  logic signed [31:0] arrival_win [WIN_MAX];
  logic signed [31:0] sorted_win [WIN_MAX];
  int unsigned        held_cnt;
  int unsigned        oldest_idx;

  logic [32:0] median_q [$];
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned rx_wait;
  bit          rx_calm;
  bit          tx_calm;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_ITEM, 7'd0, 32'h7FFF_FFFF, 1'b0, 1'b0, 33'h0},
    '{ROW_ITEM, 7'd0, 32'h8000_0000, 1'b0, 1'b0, 33'h0},
    '{ROW_ITEM, 7'd0, 32'h0000_0000, 1'b0, 1'b1, 33'h0},
    '{ROW_ITEM, 7'd0, 32'h0000_0005, 1'b0, 1'b0, 33'h0},
    '{ROW_ITEM, 7'd0, 32'h0000_0005, 1'b1, 1'b0, 33'h0},
    '{ROW_ITEM, 7'd0, 32'h0000_0005, 1'b0, 1'b0, 33'h0},
    '{ROW_ITEM, 7'd0, 32'h0000_0005, 1'b0, 1'b1, 33'h0_0000_000A},
    '{ROW_ITEM, 7'd0, 32'hFFFF_FFFD, 1'b0, 1'b0, 33'h0},
    '{ROW_CFG,  7'd1, 32'h0,         1'b0, 1'b0, 33'h0},
    '{ROW_ITEM, 7'd0, 32'h7FFF_FFFF, 1'b0, 1'b1, 33'h0_FFFF_FFFE},
    '{ROW_ITEM, 7'd0, 32'h8000_0000, 1'b0, 1'b1, 33'h1_0000_0000},
    '{ROW_CFG,  7'd0, 32'h0,         1'b0, 1'b0, 33'h0},
    '{ROW_ITEM, 7'd0, 32'hFFFF_FFFF, 1'b0, 1'b1, 33'h1_FFFF_FFFE},
    '{ROW_ITEM, 7'd0, 32'h0000_0000, 1'b1, 1'b1, 33'h0},
    '{ROW_CFG,  7'd2, 32'h0,         1'b0, 1'b0, 33'h0},
    '{ROW_ITEM, 7'd0, 32'h7FFF_FFFF, 1'b0, 1'b0, 33'h0},
    '{ROW_ITEM, 7'd0, 32'h8000_0000, 1'b0, 1'b1, 33'h1_FFFF_FFFF},
    '{ROW_ITEM, 7'd0, 32'h8000_0000, 1'b0, 1'b1, 33'h1_0000_0000},
    '{ROW_CFG,  7'd4, 32'h0,         1'b0, 1'b0, 33'h0},
    '{ROW_ITEM, 7'd0, 32'h0000_0001, 1'b0, 1'b0, 33'h0},
    '{ROW_ITEM, 7'd0, 32'h0000_0002, 1'b0, 1'b0, 33'h0},
    '{ROW_ITEM, 7'd0, 32'h0000_0003, 1'b0, 1'b0, 33'h0},
    '{ROW_ITEM, 7'd0, 32'h0000_0004, 1'b0, 1'b1, 33'h0_0000_0005},
    '{ROW_ITEM, 7'd0, 32'h0000_0007, 1'b0, 1'b0, 33'h0}
  };

  sliding_window_median_filter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned span_of(logic [6:0] w);
    if (w == 7'd0) return 1;
    if (w > WIN_MAX) return WIN_MAX;
    return {25'b0, w};
  endfunction

  function automatic void insert_sorted(logic signed [31:0] v, int unsigned count);
    int unsigned pos;
    pos = count;
    while (pos > 0 && sorted_win[pos-1] > v) begin
      sorted_win[pos] = sorted_win[pos-1];
      pos--;
    end
    sorted_win[pos] = v;
  endfunction

  // Advances the window by one sample; returns 1 when a median comes out.
  function automatic bit predict_median(logic signed [31:0] smp, logic restart,
                                        output logic [32:0] med);
    int unsigned size;
    int unsigned p;
    logic signed [32:0] lo;
    logic signed [32:0] hi;
    size = span_of(window_reg);
    med = '0;
    if (restart) begin
      held_cnt = 0;
      oldest_idx = 0;
    end
    if (held_cnt < size) begin
      arrival_win[held_cnt] = smp;
      insert_sorted(smp, held_cnt);
      held_cnt++;
      if (held_cnt < size) return 0;
      oldest_idx = 0;
    end else begin
      p = (oldest_idx >= size) ? 0 : oldest_idx;
      // Exactly one copy of the outgoing value leaves the sorted row.
      for (int unsigned i = 0; i < size; i++) begin
        if (sorted_win[i] == arrival_win[p]) begin
          for (int unsigned j = i; j + 1 < size; j++) sorted_win[j] = sorted_win[j+1];
          break;
        end
      end
      insert_sorted(smp, size - 1);
      arrival_win[p] = smp;
      p++;
      oldest_idx = (p >= size) ? 0 : p;
    end
    hi = 33'(sorted_win[size/2]);
    lo = size[0] ? hi : 33'(sorted_win[size/2 - 1]);
    med = lo + hi;
    return 1;
  endfunction

  function automatic void enqueue_median(logic [32:0] m);
    median_q.insert(median_q.size(), m);
  endfunction

  function automatic logic [31:0] draw_sample();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return 32'($urandom_range(0, 8)) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_sample(logic [31:0] smp, logic restart, logic typed,
                             logic [32:0] typed_med);
    int unsigned gap;
    logic [32:0] med;
    gap = tx_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= smp;
    s_axis_tuser_i  <= restart;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (predict_median(smp, restart, med)) enqueue_median(typed ? typed_med : med);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (median_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_window(logic [6:0] w);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= w;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    window_reg = w;
    held_cnt = 0;
    oldest_idx = 0;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Result side: random stalls, and each transfer is checked against the oldest expectation.
  initial begin
    logic [32:0] want;
    m_axis_tready_i = 1'b0;
    rx_wait = 0;
    rx_calm = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_wait > 0) begin
        m_axis_tready_i <= 1'b0;
        rx_wait--;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        if (median_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result: tdata %h", m_axis_tdata_o);
        end else begin
          want = median_q.pop_front();
          if (m_axis_tdata_o !== {7'b0, want}) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("median mismatch: expected %h, got %h", {7'b0, want}, m_axis_tdata_o);
          end
        end
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 6);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("sliding_window_median_filter_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned run_len;
    logic [6:0] w;
    err_cnt = 0;
    cycle_cnt = 0;
    tx_calm = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    window_reg = 7'd3;
    held_cnt = 0;
    oldest_idx = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_window(dir_rows[i].win);
      end else begin
        send_sample(dir_rows[i].smp, dir_rows[i].restart, dir_rows[i].typed, dir_rows[i].med);
      end
    end

    sent = 0;
    while (sent < RAND_ITEMS) begin
      case ($urandom_range(0, 15))
        0:       w = 7'd64;
        1:       w = 7'd127;
        2:       w = 7'd0;
        3:       w = 7'd1;
        4:       w = 7'($urandom_range(65, 126));
        5:       w = 7'($urandom_range(10, 63));
        default: w = 7'($urandom_range(1, 9));
      endcase
      write_window(w);
      tx_calm = ($urandom_range(0, 3) == 0);
      run_len = span_of(w) + $urandom_range(8, 60);
      repeat (run_len) begin
        if ($urandom_range(0, 199) == 0) drain_results();
        send_sample(draw_sample(), ($urandom_range(0, 39) == 0), 1'b0, '0);
        sent++;
      end
    end

    drain_results();
    repeat (4 * SETTLE_CYC) @(negedge clk_i);
    if (err_cnt == 0 && median_q.size() == 0) begin
      $display("sliding_window_median_filter_tb: done, clean");
    end else begin
      $display("sliding_window_median_filter_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/smf_pkg.sv
rtl/smf_cell.sv
rtl/sliding_window_median_filter.sv
verif/sliding_window_median_filter_tb.sv
